// ----- src/pmld_pkg.sv -----
// Shared constants and types for the polyline line-distance block.
package pmld_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	localparam int COORD_W = 16;
	localparam int DIST_W  = 16;
	localparam int MOP_W   = 19;
	localparam int PROD_W  = 2 * MOP_W;
	localparam int N_W     = 35;
	localparam int S_W     = 34;
	localparam int NSQ_W   = 66;

	localparam logic [15:0] LIMIT_RESET = 16'd16000;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_ANSWER = 2'd2
	} status_t;

	localparam logic CFG_CLOSED = 1'b0;
	localparam logic CFG_LIMIT  = 1'b1;

endpackage

// ----- src/pmld_mul.sv -----
// Shared signed multiplier with a registered product.
module pmld_mul
	import pmld_pkg::*;
(
	input  logic                     clk,
	input  logic signed [MOP_W-1:0]  op_a,
	input  logic signed [MOP_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_q
);

	// register every product
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// ----- src/pmld_store.sv -----
// Vertex memory: one write port, one registered read port.
module pmld_store
	import pmld_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [31:0]       wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [31:0]       rdata_q
);

	logic [31:0] mem_q [MAX_VERTICES];

	// write vertex
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read vertex
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

// ----- src/pmld_root.sv -----
// Iterative divide of N*N by S, then a bit-pair square root of the quotient.
module pmld_root
	import pmld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NSQ_W-1:0]  nsq,
	input  logic [S_W-1:0]    s,
	output logic              done_q,
	output logic [DIST_W-1:0] dist_q
);

	typedef enum logic [2:0] {
		R_IDLE = 3'b001,
		R_DIV  = 3'b010,
		R_SQRT = 3'b100
	} rstate_t;

	rstate_t     state_q;
	logic [4:0]  cnt_q;
	logic [S_W-1:0] rem_q;
	logic [31:0] dvd_q;
	logic [17:0] srem_q;
	logic [15:0] root_q;

	logic [S_W:0] dtrial;
	logic         dge;
	logic [19:0]  strial;
	logic [19:0]  sr2;
	logic         sge;
	logic [19:0]  sdiff;

	// one quotient bit and one root bit per step
	always_comb begin
		dtrial = {rem_q, dvd_q[31]};
		dge    = dtrial >= {1'b0, s};
		sr2    = {srem_q, dvd_q[31:30]};
		strial = {2'b00, root_q, 2'b01};
		sge    = sr2 >= strial;
		sdiff  = sr2 - strial;
	end

	// sequence divide then root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						if (nsq >= {s, 32'd0}) begin
							dist_q <= '1;
							done_q <= 1'b1;
						end else begin
							rem_q   <= nsq[NSQ_W-1:32];
							dvd_q   <= nsq[31:0];
							cnt_q   <= 5'd31;
							state_q <= R_DIV;
						end
					end
				end
				R_DIV: begin
					rem_q <= dge ? S_W'(dtrial - {1'b0, s}) : dtrial[S_W-1:0];
					dvd_q <= {dvd_q[30:0], dge};
					if (cnt_q == 5'd0) begin
						srem_q  <= '0;
						root_q  <= '0;
						cnt_q   <= 5'd15;
						state_q <= R_SQRT;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				R_SQRT: begin
					srem_q <= sge ? sdiff[17:0] : sr2[17:0];
					root_q <= {root_q[14:0], sge};
					dvd_q  <= {dvd_q[29:0], 2'b00};
					if (cnt_q == 5'd0) begin
						dist_q  <= {root_q[14:0], sge};
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

endmodule

// ----- src/polyline_min_line_distance_top.sv -----
// Top level: vertex store, pair sequencer and shared arithmetic.
//
//  channel   signals                          direction  handshake
//  command   start, busy, mode, pos_x, pos_y  in         start & !busy
//  result    done, status, min_distance       out        done, one cycle
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// Append, clear and unused mode give their result in the cycle after the command.
// A query walks the line pairs in turn: for each it reads the two vertices, runs the
// multiplier steps, then the divide and root steps, and takes the distance. After the
// last pair the answer is driven from fin_q. arst_n clears the store count and the
// control and config registers. The receiver cannot stall; busy stays high until the
// answer is out.
module polyline_min_line_distance_top
	import pmld_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                mode,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	output logic                      done,
	output logic [1:0]                status,
	output logic [DIST_W-1:0]         min_distance,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [15:0]               cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD1  = 6'b000010,
		S_RD2  = 6'b000100,
		S_LOAD = 6'b001000,
		S_MUL  = 6'b010000,
		S_ROOT = 6'b100000
	} state_t;

	state_t             state_q;
	logic               fin_q;
	logic [CNT_W-1:0]   count_q;
	logic               closed_q;
	logic [DIST_W-1:0]  limit_q;
	logic [DIST_W-1:0]  best_q;
	logic [ADDR_W-1:0]  i1_q, i2_q;
	logic               closing_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic [31:0]        v1_q, v2_q;
	logic [3:0]         mstep_q;
	logic signed [N_W-1:0] nacc_q;
	logic [S_W-1:0]     sacc_q;
	logic [NSQ_W-1:0]   nsq_q;
	logic               done_q;
	logic [1:0]         status_q;
	logic [DIST_W-1:0]  dist_out_q;

	logic               accept;
	logic               mem_we;
	logic [ADDR_W-1:0]  raddr;
	logic [31:0]        rdata;
	logic signed [MOP_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod;
	logic               root_start;
	logic               root_done;
	logic [DIST_W-1:0]  root_dist;
	logic signed [16:0] a_w, b_w;
	logic [N_W-1:0]     nneg;
	logic [32:0]        nabs;
	logic [CNT_W-1:0]   i2_next;
	logic [ADDR_W-1:0]  last_idx;

	assign busy         = (state_q != S_IDLE) || fin_q;
	assign accept       = start && !busy;
	assign done         = done_q;
	assign status       = status_q;
	assign min_distance = dist_out_q;

	assign mem_we     = accept && (mode == MODE_APPEND) && (count_q < CNT_W'(MAX_VERTICES));
	assign raddr      = (state_q == S_RD1) ? i1_q : i2_q;
	assign root_start = (state_q == S_MUL) && (mstep_q == 4'd10);
	assign i2_next    = {1'b0, i2_q} + CNT_W'(1);
	assign last_idx   = ADDR_W'(count_q - CNT_W'(1));

	pmld_store u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (count_q[ADDR_W-1:0]),
		.wdata   ({pos_y, pos_x}),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	pmld_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod)
	);

	pmld_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.nsq    (nsq_q),
		.s      (sacc_q),
		.done_q (root_done),
		.dist_q (root_dist)
	);

	// line coefficients and |N| split
	always_comb begin
		a_w  = {v2_q[31], v2_q[31:16]} - {v1_q[31], v1_q[31:16]};
		b_w  = {v1_q[15], v1_q[15:0]} - {v2_q[15], v2_q[15:0]};
		nneg = -nacc_q;
		nabs = nacc_q[N_W-1] ? nneg[32:0] : nacc_q[32:0];
	end

	// select multiplier operands by step
	always_comb begin
		case (mstep_q)
			4'd0: begin
				op_a = {{3{v2_q[15]}}, v2_q[15:0]};
				op_b = {{3{v1_q[31]}}, v1_q[31:16]};
			end
			4'd1: begin
				op_a = {{3{v1_q[15]}}, v1_q[15:0]};
				op_b = {{3{v2_q[31]}}, v2_q[31:16]};
			end
			4'd2: begin
				op_a = {{2{a_w[16]}}, a_w};
				op_b = {{3{px_q[15]}}, px_q};
			end
			4'd3: begin
				op_a = {{2{b_w[16]}}, b_w};
				op_b = {{3{py_q[15]}}, py_q};
			end
			4'd4: begin
				op_a = {{2{a_w[16]}}, a_w};
				op_b = {{2{a_w[16]}}, a_w};
			end
			4'd5: begin
				op_a = {{2{b_w[16]}}, b_w};
				op_b = {{2{b_w[16]}}, b_w};
			end
			4'd6: begin
				op_a = {1'b0, nabs[17:0]};
				op_b = {1'b0, nabs[17:0]};
			end
			4'd7: begin
				op_a = {4'd0, nabs[32:18]};
				op_b = {1'b0, nabs[17:0]};
			end
			4'd8: begin
				op_a = {4'd0, nabs[32:18]};
				op_b = {4'd0, nabs[32:18]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLOSED: closed_q <= cfg_data[0];
				CFG_LIMIT:  limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// accumulate products of the previous step
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			case (mstep_q)
				4'd1: nacc_q <= prod[N_W-1:0];
				4'd2: nacc_q <= nacc_q - prod[N_W-1:0];
				4'd3: nacc_q <= nacc_q + prod[N_W-1:0];
				4'd4: nacc_q <= nacc_q + prod[N_W-1:0];
				4'd5: sacc_q <= prod[S_W-1:0];
				4'd6: sacc_q <= sacc_q + prod[S_W-1:0];
				4'd7: nsq_q  <= {30'd0, prod[35:0]};
				4'd8: nsq_q  <= nsq_q + ({30'd0, prod[35:0]} << 19);
				4'd9: nsq_q  <= nsq_q + ({30'd0, prod[35:0]} << 36);
				default: ;
			endcase
		end
	end

	// capture query point and vertices
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
		if (state_q == S_RD2) begin
			v1_q <= rdata;
		end
		if (state_q == S_LOAD) begin
			v2_q <= rdata;
		end
	end

	// command sequencer and pair walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fin_q      <= 1'b0;
			count_q    <= '0;
			done_q     <= 1'b0;
			status_q   <= STAT_OK;
			dist_out_q <= '0;
			mstep_q    <= '0;
			closing_q  <= 1'b0;
			i1_q       <= '0;
			i2_q       <= '0;
			best_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (fin_q) begin
				// drive the query answer
				fin_q      <= 1'b0;
				done_q     <= 1'b1;
				status_q   <= STAT_ANSWER;
				dist_out_q <= best_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (mode)
							MODE_APPEND: begin
								done_q     <= 1'b1;
								dist_out_q <= '0;
								if (count_q < CNT_W'(MAX_VERTICES)) begin
									count_q  <= count_q + CNT_W'(1);
									status_q <= STAT_OK;
								end else begin
									status_q <= STAT_FULL;
								end
							end
							MODE_CLEAR: begin
								count_q    <= '0;
								done_q     <= 1'b1;
								status_q   <= STAT_OK;
								dist_out_q <= '0;
							end
							MODE_QUERY: begin
								best_q <= limit_q;
								if (count_q >= CNT_W'(2)) begin
									i1_q      <= '0;
									i2_q      <= ADDR_W'(1);
									closing_q <= 1'b0;
									state_q   <= S_RD1;
								end else if (closed_q && count_q != '0) begin
									i1_q      <= last_idx;
									i2_q      <= '0;
									closing_q <= 1'b1;
									state_q   <= S_RD1;
								end else begin
									fin_q <= 1'b1;
								end
							end
							default: begin
								done_q     <= 1'b1;
								status_q   <= STAT_OK;
								dist_out_q <= '0;
							end
						endcase
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_LOAD;
				S_LOAD: begin
					mstep_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mstep_q <= mstep_q + 4'd1;
					if (mstep_q == 4'd10) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (root_done) begin
						// keep the smaller distance, skip degenerate pairs
						if (sacc_q != '0 && root_dist < best_q) begin
							best_q <= root_dist;
						end
						if (!closing_q && i2_next < count_q) begin
							i1_q    <= i2_q;
							i2_q    <= i2_next[ADDR_W-1:0];
							state_q <= S_RD1;
						end else if (!closing_q && closed_q) begin
							i1_q      <= last_idx;
							i2_q      <= '0;
							closing_q <= 1'b1;
							state_q   <= S_RD1;
						end else begin
							fin_q   <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/pmld_checker.sv -----
// Port checker for the polyline line-distance block, bound to the top level.
module pmld_checker
	import pmld_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        mode,
	input logic              done,
	input logic [1:0]        status,
	input logic [DIST_W-1:0] min_distance
);

	// non-query transactions answer in the next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode != MODE_QUERY |=> done && !busy && status != STAT_ANSWER)
		else $error("non-query transaction not answered next cycle");

	// a query holds the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_QUERY |=> busy && !done)
		else $error("query did not raise busy");

	// a query answer ends a busy period
	a_answer_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_ANSWER |-> $past(busy))
		else $error("query answer without a busy period");

	// distance is zero on non-query results
	a_zero_distance: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_ANSWER |-> min_distance == '0)
		else $error("nonzero distance on a non-query result");

endmodule

bind polyline_min_line_distance_top pmld_checker u_pmld_checker (.*);
